FILE: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define FAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define FAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fal_pkg
// Types and constants of the fixed array list editor.
// ----------------------------------------------------------------------------
package fal_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_AT    = 4'd1,
    OP_INS_BACK  = 4'd2,
    OP_SEARCH    = 4'd3,
    OP_READ_AT   = 4'd4,
    OP_UPD_VAL   = 4'd5,
    OP_UPD_AT    = 4'd6,
    OP_DEL_VAL   = 4'd7,
    OP_DEL_AT    = 4'd8,
    OP_COPY_VAL  = 4'd9,
    OP_COPY_AT   = 4'd10,
    OP_SWAP_VAL  = 4'd11,
    OP_SWAP_AT   = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DELV,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic        [3:0]  func;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic        [5:0]  first_index;
    logic        [5:0]  second_index;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [5:0]  found_index;
    logic signed [31:0] read_value;
    logic               last;
  } out_item_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               go;
    op_e                op;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic        [5:0]  p;
    logic        [5:0]  q;
  } cell_cmd_t;

  // flags rippling from the front of the list toward the back
  typedef struct packed {
    logic zf;   // empty slot seen at or after p
    logic m1;   // entry equal to v1 seen
    logic m2;   // entry equal to v2 seen
  } fwd_link_t;

endpackage

FILE: rtl/core/fal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fal_cell
// One list slot: holds its entry and takes a new one from itself, a neighbor,
// the command or a tapped entry, driven by flags rippling along the row.
// ----------------------------------------------------------------------------
module fal_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = fal_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fal_pkg::cell_cmd_t  cmd,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  input  logic signed [31:0]  val_a,
  input  logic signed [31:0]  val_b,
  input  fal_pkg::fwd_link_t  fwd_in,
  output fal_pkg::fwd_link_t  fwd_out,
  input  logic                zb_in,
  output logic                zb_out,
  output logic signed [31:0]  val,
  output logic signed [31:0]  tap_a,
  output logic signed [31:0]  tap_b
);

  localparam logic [6:0] MY_IDX = 7'(IDX);
  localparam logic       IS_LAST = (IDX == DEPTH - 1);

  logic signed [31:0] val_r, val_nxt;
  logic m1, m2, zero, at_p, at_q, after_p, first1, first2, sel_a, sel_b;

  // local compares
  always_comb begin
    m1      = (val_r == cmd.v1);
    m2      = (val_r == cmd.v2);
    zero    = (val_r == 32'sd0);
    at_p    = (MY_IDX == {1'b0, cmd.p});
    at_q    = (MY_IDX == {1'b0, cmd.q});
    after_p = (MY_IDX > {1'b0, cmd.p});
    first1  = m1 && !fwd_in.m1;
    first2  = m2 && !fwd_in.m2;
  end

  // ripple flags to the neighbors
  always_comb begin
    fwd_out.zf = fwd_in.zf || ((at_p || after_p) && zero);
    fwd_out.m1 = fwd_in.m1 || m1;
    fwd_out.m2 = fwd_in.m2 || m2;
    zb_out     = zb_in || zero;
  end

  // value taps for read, copy and swap
  always_comb begin
    sel_a = (cmd.op == fal_pkg::OP_SWAP_VAL) ? first1 : at_p;
    sel_b = (cmd.op == fal_pkg::OP_SWAP_VAL) ? first2 : at_q;
    tap_a = sel_a ? val_r : 32'sd0;
    tap_b = sel_b ? val_r : 32'sd0;
  end

  // next entry
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      fal_pkg::OP_INS_FRONT, fal_pkg::OP_INS_AT: begin
        if (at_p) val_nxt = cmd.v1;
        else if (after_p && !fwd_in.zf) val_nxt = left_val;
      end
      fal_pkg::OP_INS_BACK: begin
        if (IS_LAST) val_nxt = cmd.v1;
        else if (!zb_in) val_nxt = right_val;
      end
      fal_pkg::OP_UPD_VAL: if (m1) val_nxt = cmd.v2;
      fal_pkg::OP_UPD_AT:  if (at_p) val_nxt = cmd.v2;
      fal_pkg::OP_DEL_VAL: if (fwd_in.m1 || m1) val_nxt = right_val;
      fal_pkg::OP_DEL_AT:  if (at_p || after_p) val_nxt = right_val;
      fal_pkg::OP_COPY_VAL: if (m2) val_nxt = cmd.v1;
      fal_pkg::OP_COPY_AT:  if (at_q) val_nxt = val_a;
      fal_pkg::OP_SWAP_VAL: begin
        if (first2) val_nxt = val_a;
        else if (first1) val_nxt = val_b;
      end
      fal_pkg::OP_SWAP_AT: begin
        if (at_p) val_nxt = val_b;
        else if (at_q) val_nxt = val_a;
      end
      default: val_nxt = val_r;
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 32'sd0;
    end else if (cmd.go) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

FILE: rtl/core/fixed_array_list_editor.sv
`timescale 1ns / 1ps
// Start in S_IDLE registers the command; S_RUN registers its result into out_item,
// and delete by value first repeats its pass in S_DELV. A search strobes one result
// per matching slot, up to MAX_RESULTS. No new command is taken while busy.
// The receiver cannot stall: each result is on out_item for one cycle only.
// Reset: synchronous rst_n clears every slot to zero (empty) and idles control.
// ----------------------------------------------------------------------------
// fixed_array_list_editor
// List of DEPTH signed words kept in a row of cells, edited by commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_array_list_editor #(
  parameter int DEPTH = fal_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fal_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output fal_pkg::out_item_t  out_item
);

  localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fal_pkg::state_t    state_r, state_nxt;
  fal_pkg::in_item_t  cmd_r;
  fal_pkg::out_item_t res_r, res_nxt;
  logic               strobe_r, strobe_nxt;
  logic [KW-1:0]      pass_r, pass_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [DEPTH-1:0]   match_r, match_nxt;

  fal_pkg::cell_cmd_t ccmd;
  fal_pkg::op_e       op;
  fal_pkg::fwd_link_t fwd [DEPTH+1];
  logic               zb [DEPTH+1];
  logic signed [31:0] vals [DEPTH];
  logic signed [31:0] taps_a [DEPTH];
  logic signed [31:0] taps_b [DEPTH];
  logic signed [31:0] val_a, val_b;
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   rest;
  logic               ok1, ok2, any1, any2, go, hit, scan_last;

  assign op   = fal_pkg::op_e'(cmd_r.func);
  assign ok1  = ({1'b0, cmd_r.first_index} < 7'(DEPTH));
  assign ok2  = ({1'b0, cmd_r.second_index} < 7'(DEPTH));
  assign any1 = fwd[DEPTH].m1;
  assign any2 = fwd[DEPTH].m2;

  // command to the cell row
  always_comb begin
    ccmd.go = go;
    ccmd.op = op;
    ccmd.v1 = cmd_r.first_value;
    ccmd.v2 = cmd_r.second_value;
    ccmd.p  = (op == fal_pkg::OP_INS_FRONT) ? 6'd0 : cmd_r.first_index;
    ccmd.q  = cmd_r.second_index;
  end

  assign fwd[0]    = '0;
  assign zb[DEPTH] = 1'b0;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lv, rv;
    if (i == 0) begin : g_l0
      assign lv = 32'sd0;
    end else begin : g_ln
      assign lv = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_rl
      assign rv = 32'sd0;
    end else begin : g_rn
      assign rv = vals[i+1];
    end
    fal_cell #(.IDX(i), .DEPTH(DEPTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (ccmd),
      .left_val (lv),
      .right_val(rv),
      .val_a    (val_a),
      .val_b    (val_b),
      .fwd_in   (fwd[i]),
      .fwd_out  (fwd[i+1]),
      .zb_in    (zb[i+1]),
      .zb_out   (zb[i]),
      .val      (vals[i]),
      .tap_a    (taps_a[i]),
      .tap_b    (taps_b[i])
    );
    assign match_vec[i] = (vals[i] == cmd_r.first_value);
  end

  // gather selected entries
  always_comb begin
    val_a = 32'sd0;
    val_b = 32'sd0;
    for (int i = 0; i < DEPTH; i++) begin
      val_a = val_a | taps_a[i];
      val_b = val_b | taps_b[i];
    end
  end

  // scan position bookkeeping
  always_comb begin
    hit       = match_r[k_r];
    rest      = match_r & ~(DEPTH'(1) << k_r);
    scan_last = (rest == '0) || (cnt_r == 4'(fal_pkg::MAX_RESULTS - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fal_pkg::S_IDLE: if (start) state_nxt = fal_pkg::S_RUN;
      fal_pkg::S_RUN: begin
        if (op == fal_pkg::OP_SEARCH && any1) state_nxt = fal_pkg::S_SCAN;
        else if (op == fal_pkg::OP_DEL_VAL && any1 && pass_nxt != '0)
          state_nxt = fal_pkg::S_DELV;
        else state_nxt = fal_pkg::S_IDLE;
      end
      fal_pkg::S_DELV: if (pass_r == KW'(1)) state_nxt = fal_pkg::S_IDLE;
      fal_pkg::S_SCAN: if (hit && scan_last) state_nxt = fal_pkg::S_IDLE;
      default: state_nxt = fal_pkg::S_IDLE;
    endcase
  end

  // outputs, cell enable and counters
  always_comb begin
    go          = 1'b0;
    strobe_nxt  = 1'b0;
    res_nxt     = '0;
    res_nxt.last = 1'b1;
    pass_nxt    = pass_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    match_nxt   = match_r;
    case (state_r)
      fal_pkg::S_RUN: begin
        strobe_nxt = 1'b1;
        pass_nxt   = KW'(DEPTH - 1);
        k_nxt      = '0;
        cnt_nxt    = '0;
        match_nxt  = match_vec;
        case (op)
          fal_pkg::OP_INS_FRONT, fal_pkg::OP_INS_BACK: go = 1'b1;
          fal_pkg::OP_INS_AT, fal_pkg::OP_UPD_AT, fal_pkg::OP_DEL_AT: begin
            go = ok1;
            if (!ok1) res_nxt.status = fal_pkg::ST_RANGE;
          end
          fal_pkg::OP_READ_AT: begin
            if (ok1) res_nxt.read_value = val_a;
            else res_nxt.status = fal_pkg::ST_RANGE;
          end
          fal_pkg::OP_SEARCH: begin
            strobe_nxt = !any1;
            if (!any1) res_nxt.status = fal_pkg::ST_NOTFOUND;
          end
          fal_pkg::OP_UPD_VAL: begin
            go = any1;
            if (!any1) res_nxt.status = fal_pkg::ST_NOTFOUND;
          end
          fal_pkg::OP_DEL_VAL: begin
            go = any1;
            strobe_nxt = !any1 || (pass_nxt == '0);
            if (!any1) res_nxt.status = fal_pkg::ST_NOTFOUND;
          end
          fal_pkg::OP_COPY_VAL, fal_pkg::OP_SWAP_VAL: begin
            go = any1 && any2;
            if (!(any1 && any2)) res_nxt.status = fal_pkg::ST_NOTFOUND;
          end
          fal_pkg::OP_COPY_AT, fal_pkg::OP_SWAP_AT: begin
            go = ok1 && ok2;
            if (!(ok1 && ok2)) res_nxt.status = fal_pkg::ST_RANGE;
          end
          default: go = 1'b0;
        endcase
      end
      fal_pkg::S_DELV: begin
        go       = 1'b1;
        pass_nxt = pass_r - KW'(1);
        if (pass_r == KW'(1)) strobe_nxt = 1'b1;
      end
      fal_pkg::S_SCAN: begin
        k_nxt     = k_r + KW'(1);
        match_nxt = rest;
        if (hit) begin
          strobe_nxt          = 1'b1;
          res_nxt.found_index = 6'(k_r);
          res_nxt.last        = scan_last;
          cnt_nxt             = cnt_r + 4'd1;
        end
      end
      default: go = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fal_pkg::S_IDLE;
      strobe_r <= 1'b0;
      pass_r   <= '0;
      k_r      <= '0;
      cnt_r    <= '0;
      match_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      pass_r   <= pass_nxt;
      k_r      <= k_nxt;
      cnt_r    <= cnt_nxt;
      match_r  <= match_nxt;
    end
  end

  // payload registers: command on input transfer, result every cycle
  always_ff @(posedge clk) begin
    if (state_r == fal_pkg::S_IDLE && start) cmd_r <= in_item;
    res_r <= res_nxt;
  end

  assign busy       = (state_r != fal_pkg::S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

  // checks
  `FAL_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted command did not raise busy")
  `FAL_ASSERT(a_strobe_after_work, out_strobe |-> $past(busy), "result without work")
  `FAL_ASSERT(a_more_pending, out_strobe && !out_item.last |-> busy,
              "search result not last but scan ended")
  `FAL_ASSERT(a_error_last, out_strobe && out_item.status != fal_pkg::ST_OK |-> out_item.last,
              "error result not final")

endmodule

FILE: tb/fixed_array_list_editor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_array_list_editor_tb
// Drives list edit commands into the editor, predicts every result from a
// private copy of the list and compares each strobed result in order.
// ----------------------------------------------------------------------------

// ordered store of predicted results plus a private copy of the list
class list_scoreboard;
  localparam int N = fal_pkg::DEPTH_DEF;
  logic [31:0] slots [N];
  fal_pkg::out_item_t pending [$];
  int mismatches;
  int checked;

  function new();
    foreach (slots[i]) slots[i] = '0;
    mismatches = 0;
    checked = 0;
  endfunction

  function int find_first(logic [31:0] v);
    for (int i = 0; i < N; i++) if (slots[i] == v) return i;
    return N;
  endfunction

  function void push_res(logic [1:0] st, logic [5:0] idx, logic [31:0] val, logic lst);
    fal_pkg::out_item_t r;
    r.status = st;
    r.found_index = idx;
    r.read_value = val;
    r.last = lst;
    pending.push_back(r);
  endfunction

  // shift toward the nearest empty slot at or after p
  function void shift_in(int p, logic [31:0] v);
    int e;
    e = N - 1;
    for (int i = p; i < N; i++) if (slots[i] == 0) begin e = i; break; end
    for (int i = e; i > p; i--) slots[i] = slots[i-1];
    slots[p] = v;
  endfunction

  function void append_back(logic [31:0] v);
    int z;
    z = 0;
    if (slots[N-1] != 0) begin
      for (int i = N - 1; i >= 0; i--) if (slots[i] == 0) begin z = i; break; end
      for (int i = z; i < N - 1; i++) slots[i] = slots[i+1];
    end
    slots[N-1] = v;
  endfunction

  // note one accepted command transfer
  function void note_cmd(fal_pkg::in_item_t c);
    logic [31:0] v1, v2, t;
    int i1, i2, a, b, k, j;
    logic [1:0] st;
    logic [31:0] rv;
    v1 = c.first_value;
    v2 = c.second_value;
    i1 = int'(c.first_index);
    i2 = int'(c.second_index);
    st = fal_pkg::ST_OK;
    rv = '0;
    case (c.func)
      fal_pkg::OP_INS_FRONT: shift_in(0, v1);
      fal_pkg::OP_INS_AT:
        if (i1 >= N) st = fal_pkg::ST_RANGE; else shift_in(i1, v1);
      fal_pkg::OP_INS_BACK: append_back(v1);
      fal_pkg::OP_SEARCH: begin
        k = 0;
        for (int i = 0; i < N && k < fal_pkg::MAX_RESULTS; i++)
          if (slots[i] == v1) begin
            push_res(fal_pkg::ST_OK, 6'(i), '0, 1'b0);
            k++;
          end
        if (k == 0) push_res(fal_pkg::ST_NOTFOUND, '0, '0, 1'b1);
        else pending[$].last = 1'b1;
        return;
      end
      fal_pkg::OP_READ_AT:
        if (i1 >= N) st = fal_pkg::ST_RANGE; else rv = slots[i1];
      fal_pkg::OP_UPD_VAL:
        if (find_first(v1) >= N) st = fal_pkg::ST_NOTFOUND;
        else foreach (slots[i]) if (slots[i] == v1) slots[i] = v2;
      fal_pkg::OP_UPD_AT:
        if (i1 >= N) st = fal_pkg::ST_RANGE; else slots[i1] = v2;
      fal_pkg::OP_DEL_VAL:
        if (find_first(v1) >= N) st = fal_pkg::ST_NOTFOUND;
        else begin
          j = 0;
          for (int i = 0; i < N; i++) if (slots[i] != v1) begin slots[j] = slots[i]; j++; end
          for (; j < N; j++) slots[j] = '0;
        end
      fal_pkg::OP_DEL_AT:
        if (i1 >= N) st = fal_pkg::ST_RANGE;
        else begin
          for (int i = i1; i < N - 1; i++) slots[i] = slots[i+1];
          slots[N-1] = '0;
        end
      fal_pkg::OP_COPY_VAL:
        if (find_first(v1) >= N || find_first(v2) >= N) st = fal_pkg::ST_NOTFOUND;
        else foreach (slots[i]) if (slots[i] == v2) slots[i] = v1;
      fal_pkg::OP_COPY_AT:
        if (i1 >= N || i2 >= N) st = fal_pkg::ST_RANGE; else slots[i2] = slots[i1];
      fal_pkg::OP_SWAP_VAL: begin
        a = find_first(v1);
        b = find_first(v2);
        if (a >= N || b >= N) st = fal_pkg::ST_NOTFOUND;
        else begin t = slots[a]; slots[a] = slots[b]; slots[b] = t; end
      end
      fal_pkg::OP_SWAP_AT:
        if (i1 >= N || i2 >= N) st = fal_pkg::ST_RANGE;
        else begin t = slots[i1]; slots[i1] = slots[i2]; slots[i2] = t; end
      default: ;
    endcase
    push_res(st, '0, rv, 1'b1);
  endfunction

  // compare one strobed result with the oldest prediction
  function void check_res(fal_pkg::out_item_t got);
    fal_pkg::out_item_t exp_r;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status || got.found_index !== exp_r.found_index ||
        got.read_value !== exp_r.read_value || got.last !== exp_r.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: exp st=%0d idx=%0d val=%h last=%0b, %s",
                 exp_r.status, exp_r.found_index, exp_r.read_value, exp_r.last,
                 $sformatf("got st=%0d idx=%0d val=%h last=%0b",
                           got.status, got.found_index, got.read_value, got.last));
    end
  endfunction
endclass

module fixed_array_list_editor_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  fal_pkg::in_item_t in_item = '0;
  logic out_strobe;
  fal_pkg::out_item_t out_item;

  list_scoreboard sb;
  int n_sent = 0;
  logic [31:0] pool [8];

  fixed_array_list_editor u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_strobe && sb != null) sb.check_res(out_item);
  end

  // hold start until the command transfer happens
  task automatic send_cmd(logic [3:0] f, logic [31:0] v1, logic [31:0] v2,
                          logic [5:0] p, logic [5:0] q);
    fal_pkg::in_item_t c;
    c.func = f;
    c.first_value = v1;
    c.second_value = v2;
    c.first_index = p;
    c.second_index = q;
    start <= 1'b1;
    in_item <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(c);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // values from a small pool so searches and by-value edits hit often
  function automatic logic [31:0] pick_val();
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_idx();
    if ($urandom_range(0, 9) < 8) return 6'($urandom_range(0, fal_pkg::DEPTH_DEF - 1));
    return 6'($urandom);
  endfunction

  initial begin
    int burst;
    logic [3:0] f;
    sb = new();
    pool[0] = 32'h0000_0000; pool[1] = 32'h8000_0000; pool[2] = 32'h7FFF_FFFF;
    pool[3] = 32'hFFFF_FFFF; pool[4] = 32'd1; pool[5] = 32'd5;
    pool[6] = 32'hAAAA_5555; pool[7] = 32'd5;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every op and the special cases
    send_cmd(fal_pkg::OP_SEARCH, 32'd7, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_DEL_VAL, 32'd7, 32'd0, 6'd0, 6'd0);
    for (int i = 0; i < fal_pkg::DEPTH_DEF; i++)
      send_cmd(fal_pkg::OP_INS_BACK, 32'd5, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_SEARCH, 32'd5, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_INS_FRONT, 32'h8000_0000, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_INS_BACK, 32'h7FFF_FFFF, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_INS_AT, 32'hFFFF_FFFF, 32'd0, 6'd63, 6'd0);
    send_cmd(fal_pkg::OP_INS_AT, 32'hFFFF_FFFF, 32'd0, 6'd15, 6'd0);
    send_cmd(fal_pkg::OP_READ_AT, 32'd0, 32'd0, 6'd15, 6'd0);
    send_cmd(fal_pkg::OP_READ_AT, 32'd0, 32'd0, 6'd16, 6'd0);
    send_cmd(fal_pkg::OP_UPD_VAL, 32'd5, 32'd9, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_UPD_AT, 32'd0, 32'd0, 6'd3, 6'd0);
    send_cmd(fal_pkg::OP_DEL_AT, 32'd0, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_COPY_VAL, 32'h7FFF_FFFF, 32'd9, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_COPY_AT, 32'd0, 32'd0, 6'd1, 6'd40);
    send_cmd(fal_pkg::OP_COPY_AT, 32'd0, 32'd0, 6'd1, 6'd2);
    send_cmd(fal_pkg::OP_SWAP_VAL, 32'h7FFF_FFFF, 32'h0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_SWAP_AT, 32'd0, 32'd0, 6'd0, 6'd15);
    send_cmd(4'd13, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 6'h3F);
    send_cmd(4'd15, 32'd0, 32'd0, 6'd0, 6'd0);
    send_cmd(fal_pkg::OP_DEL_VAL, 32'h7FFF_FFFF, 32'd0, 6'd0, 6'd0);
    idle_cycles(3);

    // random bursts with random gaps
    while (n_sent < 260) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                         : 4'($urandom_range(0, 12));
        send_cmd(f, pick_val(), pick_val(), pick_idx(), pick_idx());
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 9));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3 * fal_pkg::DEPTH_DEF) @(posedge clk);
    $display("ran %0d commands over all operations, %0d results checked",
             n_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
